[rtl/tpim_pkg.sv]
// Types and constants shared by the triangular pair index map files.
`timescale 1ns / 1ps
package tpim_pkg;

  localparam int unsigned ITEM_W     = 12;
  localparam int unsigned IDX_W      = 24;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned ITEM_LIMIT = 4096;

  // Radicand is 8*index+1; its root is found one bit pair per stage.
  localparam int unsigned RAD_W      = IDX_W + 3;
  localparam int unsigned RES_W      = RAD_W + 1;
  localparam int unsigned SQ_STAGES  = (RAD_W + 1) / 2;
  localparam int unsigned ROOT_W     = SQ_STAGES;
  localparam int unsigned H_W        = ROOT_W - 1;
  localparam int unsigned PROD_W     = 2 * H_W + 1;

  localparam logic OP_PAIR_TO_INDEX = 1'b0;
  localparam logic OP_INDEX_TO_PAIR = 1'b1;

  localparam logic [0:0] CFG_ITEM_COUNT  = 1'd0;
  localparam logic [0:0] CFG_CHECK_RANGE = 1'd1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ITEM_RANGE  = 2'd1,
    ST_WRONG_ORDER = 2'd2,
    ST_INDEX_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic              opcode;
    logic [ITEM_W-1:0] item_low;
    logic [ITEM_W-1:0] item_high;
    logic [IDX_W-1:0]  pair_index;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  result_index;
    logic [ITEM_W-1:0] result_low;
    logic [ITEM_W-1:0] result_high;
    status_t           status;
  } out_t;

  // Classified transaction as it sits in the queue.
  typedef struct packed {
    in_t     item;
    status_t fstat;
  } q_t;

endpackage

[rtl/tpim_front.sv]
// Front end: classifies incoming transactions by direction and pair checks.
`timescale 1ns / 1ps
module tpim_front (
  input  tpim_pkg::in_t               in_item,
  input  logic [tpim_pkg::CNT_W-1:0]  cnt,
  input  logic                        check_range,
  output tpim_pkg::q_t                q_item
);
  import tpim_pkg::*;

  logic lo_out, hi_out;

  assign lo_out = {1'b0, in_item.item_low}  >= cnt;
  assign hi_out = {1'b0, in_item.item_high} >= cnt;

  always_comb begin
    q_item.item  = in_item;
    q_item.fstat = ST_OK;
    // The reverse direction is range checked after the root is known.
    if (in_item.opcode == OP_PAIR_TO_INDEX) begin
      priority if (check_range && (lo_out || hi_out)) begin
        q_item.fstat = ST_ITEM_RANGE;
      end else if (in_item.item_low > in_item.item_high) begin
        q_item.fstat = ST_WRONG_ORDER;
      end else begin
        q_item.fstat = ST_OK;
      end
    end
  end

endmodule

[rtl/tpim_queue.sv]
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module tpim_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tpim_pkg::q_t  push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output tpim_pkg::q_t  head
);
  import tpim_pkg::*;

  q_t         mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/tpim_back.sv]
// Back end: pipelined square root, triangular product and result register.
`timescale 1ns / 1ps
module tpim_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  tpim_pkg::q_t                q_head,
  output logic                        q_pop,
  input  logic [tpim_pkg::CNT_W-1:0]  limit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tpim_pkg::out_t              out_data
);
  import tpim_pkg::*;

  typedef struct packed {
    logic              opcode;
    logic [ITEM_W-1:0] lo;
    logic [ITEM_W-1:0] hi;
    logic [IDX_W-1:0]  idx;
    status_t           fstat;
    logic [RAD_W-1:0]  rem;
    logic [RES_W-1:0]  res;
  } pipe_t;

  typedef struct packed {
    logic              opcode;
    logic [ITEM_W-1:0] lo;
    logic [IDX_W-1:0]  idx;
    logic [H_W-1:0]    h;
    status_t           stat;
    logic [PROD_W-1:0] prod;
  } mul_t;

  // One bit pair of the restoring square root.
  function automatic pipe_t sqrt_step(pipe_t p, logic [RES_W-1:0] b);
    pipe_t            q;
    logic [RES_W-1:0] t;
    q = p;
    t = p.res + b;
    if ({1'b0, p.rem} >= t) begin
      q.rem = RAD_W'({1'b0, p.rem} - t);
      q.res = (p.res >> 1) + b;
    end else begin
      q.res = p.res >> 1;
    end
    return q;
  endfunction

  pipe_t  stg_in [SQ_STAGES];
  pipe_t  stg_r  [SQ_STAGES];
  logic   vld_r  [SQ_STAGES];
  pipe_t  init;
  pipe_t  last;
  mul_t   mul_r;
  logic   mul_vld_r;
  logic   adv;
  out_t   out_r;
  logic   out_vld_r;

  logic [ROOT_W-1:0]    root;
  logic [H_W-1:0]       h;
  logic [H_W-1:0]       n;
  status_t              stat;
  logic [PROD_W-2:0]    tri_v;
  logic [PROD_W-2:0]    lo_diff;
  logic [IDX_W-1:0]     fwd_idx;
  out_t                 out_nxt;

  // The whole back end moves as one when the result register can take data.
  assign adv   = !out_vld_r || !out_stall;
  assign q_pop = adv;

  always_comb begin
    init.opcode = q_head.item.opcode;
    init.lo     = q_head.item.item_low;
    init.hi     = q_head.item.item_high;
    init.idx    = q_head.item.pair_index;
    init.fstat  = q_head.fstat;
    init.rem    = {q_head.item.pair_index, 3'b001};
    init.res    = '0;
  end

  assign stg_in[0] = init;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    localparam int unsigned SH = RAD_W - 1 - 2 * k;
    localparam logic [RES_W-1:0] BIT = RES_W'(1) << SH;
    if (k > 0) begin : g_link
      assign stg_in[k] = stg_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= sqrt_step(stg_in[k], BIT);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= (k == 0) ? q_valid : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign last = stg_r[SQ_STAGES-1];
  assign root = last.res[ROOT_W-1:0];
  // Largest h with h*(h+1)/2 <= index.
  assign h    = H_W'((root - ROOT_W'(1)) >> 1);
  assign n    = (last.opcode == OP_INDEX_TO_PAIR) ? h : H_W'(last.hi);

  always_comb begin
    stat = last.fstat;
    if (last.opcode == OP_INDEX_TO_PAIR) begin
      stat = (h >= limit) ? ST_INDEX_RANGE : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_r.opcode <= last.opcode;
      mul_r.lo     <= last.lo;
      mul_r.idx    <= last.idx;
      mul_r.h      <= h;
      mul_r.stat   <= stat;
      mul_r.prod   <= PROD_W'(n * ({1'b0, n} + (H_W+1)'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (adv) begin
      mul_vld_r <= vld_r[SQ_STAGES-1];
    end
  end

  assign tri_v   = mul_r.prod[PROD_W-1:1];
  assign lo_diff = (PROD_W-1)'(mul_r.idx) - tri_v;
  assign fwd_idx = IDX_W'(tri_v + (PROD_W-1)'(mul_r.lo));

  always_comb begin
    out_nxt.result_index = '0;
    out_nxt.result_low   = '0;
    out_nxt.result_high  = '0;
    out_nxt.status       = mul_r.stat;
    if (mul_r.stat == ST_OK) begin
      if (mul_r.opcode == OP_PAIR_TO_INDEX) begin
        out_nxt.result_index = fwd_idx;
      end else begin
        out_nxt.result_low  = lo_diff[ITEM_W-1:0];
        out_nxt.result_high = mul_r.h[ITEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= mul_vld_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[rtl/triangular_pair_index_map.sv]
// Top level of the triangular pair index map: config registers and the two halves.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------
//  in_      | input     | in_valid/in_stall  | in_data  (opcode, pair, index)
//  out_     | output    | out_valid/out_stall| out_data (index, pair, status)
//  cfg_     | input     | cfg_we             | cfg_index, cfg_wdata
//
// One transaction is accepted per cycle and one result leaves per cycle when
// the output is not stalled. Each transaction passes through the queue, the
// 14 square root stages (one root bit each), the triangular product stage and
// the result register. Reset is synchronous and active low; it empties the queue
// and the pipeline and restores item_count to 4096 and check_range to 1. A stall
// on the output freezes the back end as a whole; the two-entry queue then fills
// and in_stall rises.
module triangular_pair_index_map #(
  parameter int unsigned MAX_ITEMS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tpim_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tpim_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [tpim_pkg::CNT_W-1:0]   cfg_wdata
);
  import tpim_pkg::*;

  // Items beyond 4096 cannot be named by a 12-bit item field.
  localparam int unsigned CAP_ITEMS = (MAX_ITEMS < ITEM_LIMIT) ? MAX_ITEMS : ITEM_LIMIT;
  localparam logic [CNT_W-1:0] CAP  = CNT_W'(CAP_ITEMS);

  logic [CNT_W-1:0] item_count_r;
  logic             check_range_r;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] limit;

  q_t   front_item;
  q_t   q_head;
  logic q_full, q_valid, q_pop;

  // Config writes; only the user keeps the block idle whenever these happen.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r  <= CNT_W'(ITEM_LIMIT);
      check_range_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ITEM_COUNT:  item_count_r  <= cfg_wdata;
        CFG_CHECK_RANGE: check_range_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective item count, and the bound the unpacked high item must stay under.
  assign cnt   = (item_count_r < CAP) ? item_count_r : CAP;
  assign limit = check_range_r ? cnt : CAP;

  assign in_stall = q_full;

  tpim_front u_front (
    .in_item     (in_data),
    .cnt         (cnt),
    .check_range (check_range_r),
    .q_item      (front_item)
  );

  tpim_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tpim_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .limit     (limit),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/tpim_checker.sv]
// Port-level checker for the triangular pair index map, bound to the top level.
`timescale 1ns / 1ps
module tpim_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input tpim_pkg::out_t out_data
);
  import tpim_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.result_index == '0 && out_data.result_low == '0 &&
      out_data.result_high == '0)
    else $error("error result carries nonzero fields");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_index != '0 |->
      out_data.result_low == '0 && out_data.result_high == '0)
    else $error("result mixes both directions");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.result_low <= out_data.result_high)
    else $error("unpacked pair out of order");

endmodule

bind triangular_pair_index_map tpim_checker u_tpim_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[bench/tb_triangular_pair_index_map.sv]
// Self-checking testbench for the triangular pair index map.
`timescale 1ns / 1ps

module tb_triangular_pair_index_map;
  import tpim_pkg::*;

  // The block is built with its default capacity. Every predicted item number is
  // bounded by this capacity, every packed index by its triangular number.
  localparam int unsigned     MAX_ITEMS = 4096;
  localparam longint unsigned CAPACITY  = (MAX_ITEMS < ITEM_LIMIT) ? MAX_ITEMS : ITEM_LIMIT;

  // The slack after each drain lets any stray result show up before the next
  // register write or before the end.
  localparam int unsigned DRAIN_SLACK    = 40;
  // The longest quiet stretch in a correct run is the receiver hold-off below,
  // plus the longest sender gap. The watchdog limit is several times that.
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_ITEMS    = 100;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_we    = 1'b0;
  logic [0:0]             cfg_index = CFG_ITEM_COUNT;
  logic [CNT_W-1:0]       cfg_wdata = '0;

  // One row of the directed table. When typed is set, the row carries the
  // expected result written by hand; otherwise the predictor supplies it.
  typedef struct {
    logic [CNT_W-1:0] cnt;
    logic             chk;
    in_t              req;
    bit               typed;
    out_t             result;
  } dir_row_t;

  dir_row_t         directed_rows[$];
  out_t             expected_results[$];

  // Register shadow copies, updated once the block's registers have been written.
  logic [CNT_W-1:0] cur_item_count  = CNT_W'(4096);
  logic             cur_check_range = 1'b1;

  int unsigned      requests_sent    = 0;
  int unsigned      results_checked  = 0;
  int unsigned      mismatch_count   = 0;
  int unsigned      settings_used    = 0;
  int unsigned      status_seen[4]   = '{0, 0, 0, 0};
  int unsigned      burst_left       = 0;
  int unsigned      quiet_cycles     = 0;
  bit               hold_req         = 1'b0;

  triangular_pair_index_map #(
    .MAX_ITEMS(MAX_ITEMS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever begin
      #6 clk = ~clk;
    end
  end

  // Triangular number n*(n+1)/2, wide enough for any 13-bit count.
  function automatic longint unsigned tri_num(longint unsigned n);
    return (n * (n + 1)) / 2;
  endfunction

  // Predicts the result of one request under the given register settings.
  // The inverse searches for the largest row h whose triangular start does
  // not exceed the index, which is what the exact square root yields.
  function automatic out_t map_request(in_t req, logic [CNT_W-1:0] cnt_reg, logic chk);
    longint unsigned eff;
    longint unsigned limit;
    longint unsigned sum;
    longint unsigned row_lo;
    longint unsigned row_hi;
    longint unsigned mid;
    out_t            r;
    r        = '0;
    r.status = ST_OK;
    eff      = (cnt_reg < CAPACITY) ? cnt_reg : CAPACITY;
    if (req.opcode == OP_PAIR_TO_INDEX) begin
      if (chk && (req.item_low >= eff || req.item_high >= eff)) begin
        r.status = ST_ITEM_RANGE;
      end else if (req.item_low > req.item_high) begin
        r.status = ST_WRONG_ORDER;
      end else begin
        sum            = req.item_low + tri_num(req.item_high);
        r.result_index = sum[IDX_W-1:0];
      end
    end else begin
      limit = chk ? tri_num(eff) : tri_num(CAPACITY);
      if (req.pair_index >= limit) begin
        r.status = ST_INDEX_RANGE;
      end else begin
        row_lo = 0;
        row_hi = CAPACITY - 1;
        while (row_lo < row_hi) begin
          mid = (row_lo + row_hi + 1) / 2;
          if (tri_num(mid) <= req.pair_index) row_lo = mid;
          else row_hi = mid - 1;
        end
        sum           = req.pair_index - tri_num(row_lo);
        r.result_high = row_lo[ITEM_W-1:0];
        r.result_low  = sum[ITEM_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic in_t pair_req(logic [ITEM_W-1:0] lo, logic [ITEM_W-1:0] hi,
                                   logic [IDX_W-1:0] junk);
    in_t r;
    r.opcode     = OP_PAIR_TO_INDEX;
    r.item_low   = lo;
    r.item_high  = hi;
    r.pair_index = junk;
    return r;
  endfunction

  function automatic in_t index_req(logic [IDX_W-1:0] idx, logic [ITEM_W-1:0] junk_lo,
                                    logic [ITEM_W-1:0] junk_hi);
    in_t r;
    r.opcode     = OP_INDEX_TO_PAIR;
    r.item_low   = junk_lo;
    r.item_high  = junk_hi;
    r.pair_index = idx;
    return r;
  endfunction

  function automatic out_t make_result(logic [IDX_W-1:0] idx, logic [ITEM_W-1:0] lo,
                                       logic [ITEM_W-1:0] hi, status_t st);
    out_t r;
    r.result_index = idx;
    r.result_low   = lo;
    r.result_high  = hi;
    r.status       = st;
    return r;
  endfunction

  task automatic add_row(logic [CNT_W-1:0] cnt, logic chk, in_t req, bit typed, out_t res);
    dir_row_t row;
    row.cnt    = cnt;
    row.chk    = chk;
    row.req    = req;
    row.typed  = typed;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  // Random request shaped by the current settings. Most requests are well
  // formed and in range so that the square root path sees real work; the
  // rest sit on boundaries, break the order, or are plain random bits.
  function automatic in_t random_request(logic [CNT_W-1:0] cnt_reg, logic chk);
    longint unsigned eff;
    longint unsigned span;
    longint unsigned limit;
    longint unsigned a;
    longint unsigned b;
    longint unsigned k;
    int unsigned     sel;
    in_t             r;
    eff   = (cnt_reg < CAPACITY) ? cnt_reg : CAPACITY;
    span  = chk ? eff : CAPACITY;
    limit = tri_num(span);
    sel   = $urandom_range(0, 9);
    if ($urandom_range(0, 1) == 0) begin
      if (span == 0 || sel >= 8) begin
        a = $urandom_range(0, 4095);
        b = $urandom_range(0, 4095);
      end else if (sel == 7) begin
        // Top of the valid range, or one past it.
        b = span - 1 + $urandom_range(0, 1);
        if (b > 4095) b = 4095;
        a = $urandom_range(0, b);
      end else begin
        a = $urandom_range(0, span - 1);
        b = $urandom_range(0, span - 1);
        // Ordered pairs mostly; sel 6 deliberately swaps them.
        if ((sel == 6) == (a < b)) begin
          k = a;
          a = b;
          b = k;
        end
      end
      r = pair_req(a[ITEM_W-1:0], b[ITEM_W-1:0], IDX_W'($urandom));
    end else begin
      if (limit == 0 || sel >= 8) begin
        a = $urandom_range(0, (1 << IDX_W) - 1);
      end else if (sel == 7) begin
        // Exact start of a row, or the last index of the row before it.
        k = $urandom_range(1, span);
        a = tri_num(k) - $urandom_range(0, 1);
        if (k == span) a = limit - 1;
      end else if (sel == 6) begin
        a = limit - 1 + $urandom_range(0, 2);
      end else begin
        a = $urandom % limit;
      end
      r = index_req(a[IDX_W-1:0], ITEM_W'($urandom), ITEM_W'($urandom));
    end
    return r;
  endfunction

  // Offers one transaction from the falling edge on and holds it until the
  // block takes it. The expectation is queued at the accepting rising edge.
  task automatic send_item(in_t req, bit typed, out_t typed_result);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    if (typed) expected_results.push_back(typed_result);
    else expected_results.push_back(map_request(req, cur_item_count, cur_check_range));
    requests_sent++;
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Sender pacing: bursts of random length separated by random gaps, where a
  // gap of zero joins two bursts into one unbroken stretch.
  task automatic pace_sender();
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) == 0) idle_cycles(0);
      else idle_cycles($urandom_range(1, 8));
      burst_left = $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  // Lowers valid and waits until every expected result has been checked,
  // then a little longer so that nothing is still in flight.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Registers change only with the block empty. The upper bits of the
  // check_range write are random since the block keeps only bit zero.
  task automatic set_config(logic [CNT_W-1:0] cnt, logic chk);
    wait_all_results();
    write_reg(CFG_ITEM_COUNT, cnt);
    write_reg(CFG_CHECK_RANGE, {(CNT_W-1)'($urandom), chk});
    cur_item_count  = cnt;
    cur_check_range = chk;
    settings_used++;
  endtask

  // Receiver: a stall pattern that changes mode every so often, plus one long
  // hold-off on request that it counts out itself.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= ((tick % 7) < 3);
          end
        endcase
      end
    end
  end

  // Result checker: every accepted result is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("Result with no request outstanding: index %0d low %0d high %0d status %0d",
               out_data.result_index, out_data.result_low, out_data.result_high,
               out_data.status);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        status_seen[exp_res.status]++;
        if (out_data.result_index !== exp_res.result_index) begin
          $error("result_index: expected %0d, actual %0d", exp_res.result_index,
                 out_data.result_index);
          mismatch_count++;
        end
        if (out_data.result_low !== exp_res.result_low) begin
          $error("result_low: expected %0d, actual %0d", exp_res.result_low,
                 out_data.result_low);
          mismatch_count++;
        end
        if (out_data.result_high !== exp_res.result_high) begin
          $error("result_high: expected %0d, actual %0d", exp_res.result_high,
                 out_data.result_high);
          mismatch_count++;
        end
        if (out_data.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for
  // far longer than any correct run can stay quiet.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [CNT_W-1:0] phase_cnt[9];
    logic             phase_chk[9];
    out_t             none;
    none = '0;

    // Directed table. Rows are grouped by register setting; the first group
    // runs with the values that reset leaves behind.
    add_row(4096, 1, pair_req(0, 0, 0), 1, make_result(0, 0, 0, ST_OK));
    add_row(4096, 1, pair_req(4095, 4095, 0), 1, make_result(8390655, 0, 0, ST_OK));
    add_row(4096, 1, pair_req(0, 4095, 0), 1, make_result(8386560, 0, 0, ST_OK));
    add_row(4096, 1, pair_req(1, 0, 0), 1, make_result(0, 0, 0, ST_WRONG_ORDER));
    add_row(4096, 1, pair_req(4095, 0, 0), 1, make_result(0, 0, 0, ST_WRONG_ORDER));
    add_row(4096, 1, index_req(0, 0, 0), 1, make_result(0, 0, 0, ST_OK));
    add_row(4096, 1, index_req(8390655, 0, 0), 1, make_result(0, 4095, 4095, ST_OK));
    add_row(4096, 1, index_req(8390656, 0, 0), 1, make_result(0, 0, 0, ST_INDEX_RANGE));
    add_row(4096, 1, index_req(24'hFFFFFF, 0, 0), 1, make_result(0, 0, 0, ST_INDEX_RANGE));
    add_row(4096, 1, index_req(8386559, 0, 0), 0, none);
    // Fields that the opcode does not use carry all ones.
    add_row(4096, 1, pair_req(7, 300, 24'hFFFFFF), 0, none);
    add_row(4096, 1, index_req(12345, 12'hFFF, 12'hFFF), 0, none);
    // Small count: range errors win over wrong order.
    add_row(10, 1, pair_req(10, 3, 0), 1, make_result(0, 0, 0, ST_ITEM_RANGE));
    add_row(10, 1, pair_req(3, 10, 0), 1, make_result(0, 0, 0, ST_ITEM_RANGE));
    add_row(10, 1, pair_req(9, 9, 0), 0, none);
    add_row(10, 1, pair_req(9, 2, 0), 1, make_result(0, 0, 0, ST_WRONG_ORDER));
    add_row(10, 1, index_req(55, 0, 0), 1, make_result(0, 0, 0, ST_INDEX_RANGE));
    add_row(10, 1, index_req(54, 0, 0), 1, make_result(0, 9, 9, ST_OK));
    // A count of zero with checking on rejects everything.
    add_row(0, 1, pair_req(0, 0, 0), 1, make_result(0, 0, 0, ST_ITEM_RANGE));
    add_row(0, 1, index_req(0, 0, 0), 1, make_result(0, 0, 0, ST_INDEX_RANGE));
    // A count above the capacity acts as the capacity.
    add_row(8191, 1, pair_req(4095, 4095, 0), 1, make_result(8390655, 0, 0, ST_OK));
    add_row(8191, 1, index_req(8390656, 0, 0), 1, make_result(0, 0, 0, ST_INDEX_RANGE));
    // Checking off: only the order matters forward, only capacity in reverse.
    add_row(10, 0, pair_req(100, 4000, 0), 0, none);
    add_row(10, 0, pair_req(200, 100, 0), 1, make_result(0, 0, 0, ST_WRONG_ORDER));
    add_row(10, 0, index_req(8390655, 0, 0), 0, none);
    add_row(10, 0, index_req(8390656, 0, 0), 1, make_result(0, 0, 0, ST_INDEX_RANGE));

    // Settings for the random phases, the extremes among them.
    phase_cnt = '{4096, 1, 2, 0, 8191, 8191, 37, 13'($urandom_range(1, 4096)),
                  13'($urandom_range(0, 8191))};
    phase_chk = '{1, 1, 0, 1, 1, 0, 1, 1, 1'($urandom_range(0, 1))};

    // Synchronous reset, released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cnt != cur_item_count ||
          directed_rows[i].chk != cur_check_range) begin
        set_config(directed_rows[i].cnt, directed_rows[i].chk);
      end
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);
      pace_sender();
    end

    for (int p = 0; p < 9; p++) begin
      set_config(phase_cnt[p], phase_chk[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Long receiver hold-off while the sender keeps offering, so that
        // the block fills up and stalls its input.
        if (p == 2 && n == 30) hold_req = 1'b1;
        // Sender pause in mid-phase until every result is back.
        if (p == 5 && n == 50) wait_all_results();
        send_item(random_request(cur_item_count, cur_check_range), 0, none);
        pace_sender();
      end
    end

    wait_all_results();

    $display("Checked %0d results for %0d requests under %0d register settings.",
             results_checked, requests_sent, settings_used);
    $display("Status mix: %0d ok, %0d item range, %0d wrong order, %0d index range.",
             status_seen[ST_OK], status_seen[ST_ITEM_RANGE], status_seen[ST_WRONG_ORDER],
             status_seen[ST_INDEX_RANGE]);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
